[rtl/core/bom_pkg.sv]
// ----------------------------------------------------------------------------
// bom_pkg: blob orientation shared definitions
// Field widths, side-flag bundle, CORDIC arctangent table and scale constants.
// ----------------------------------------------------------------------------
package bom_pkg;

    localparam int MOMENT_W = 32;
    localparam int ANGLE_W  = 24;

    // datapath widths
    localparam int DIFF_W  = MOMENT_W + 1;   // a = h - v, b = 2 * mixed
    localparam int CORD_W  = 46;             // x/y after normalization and CORDIC gain
    localparam int ZACC_W  = 33;             // angle accumulator, 2^-32 turn units
    localparam int THETA_W = 32;             // theta in units of pi / 2^31
    localparam int PROD_W  = 63;
    localparam int NORM_MSB = 40;            // larger magnitude lands in [2^40, 2^41)
    localparam int TAB_DEPTH = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 24'd11796479;
    localparam logic [30:0]        PI_Q29    = 31'd1686629713;
    localparam logic [30:0]        DEG_SCALE = 31'd45;
    localparam logic [63:0]        RAD_ROUND = 64'd1 << 43;
    localparam logic [63:0]        DEG_ROUND = 64'd1 << 12;
    localparam int                 RAD_SHIFT = 44;
    localparam int                 DEG_SHIFT = 13;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [29:0] ATAN_TAB [TAB_DEPTH] = '{
        30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
        30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
        30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001,
        30'h00000000, 30'h00000000
    };

    // per-item flags that ride along the pipeline
    typedef struct packed {
        logic last;
        logic a_zero;
        logic a_neg;
        logic b_neg;
        logic b_zero;
    } t_side;

endpackage

[rtl/core/bom_in_if.sv]
// ----------------------------------------------------------------------------
// bom_in_if: moment request channel
// Valid/ready channel carrying the three central moments and the last flag.
// ----------------------------------------------------------------------------
interface bom_in_if;
    import bom_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MOMENT_W-1:0] moment_horizontal;
    logic signed [MOMENT_W-1:0] moment_vertical;
    logic signed [MOMENT_W-1:0] moment_mixed;
    logic                       last_blob_in;

    modport source (
        output valid, moment_horizontal, moment_vertical, moment_mixed, last_blob_in,
        input  ready
    );
    modport sink (
        input  valid, moment_horizontal, moment_vertical, moment_mixed, last_blob_in,
        output ready
    );
endinterface

[rtl/core/bom_out_if.sv]
// ----------------------------------------------------------------------------
// bom_out_if: orientation result channel
// Valid/ready channel carrying the Q8.16 angle and the last flag.
// ----------------------------------------------------------------------------
interface bom_out_if;
    import bom_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic               last_blob_out;

    modport source (
        output valid, angle, last_blob_out,
        input  ready
    );
    modport sink (
        input  valid, angle, last_blob_out,
        output ready
    );
endinterface

[rtl/core/blob_orientation_from_moments.sv]
// ----------------------------------------------------------------------------
// blob_orientation_from_moments: major-axis angle from central moments
// Pipelined vectoring CORDIC, result folded into [0, pi), radians or degrees.
// ----------------------------------------------------------------------------
// Accepts one blob request per clock and returns one angle per request, in
// order. Four stages form the moment difference, take magnitudes, find the
// normalizing shift and apply it, one stage per CORDIC iteration follows,
// then one stage folds the half angle, one multiplies by the radian or degree
// scale and one rounds and saturates into the output register. Each stage
// holds its request while the one after it is full, so throughput is one
// per cycle whenever the result side takes one per cycle. The user must write
// degree_mode through i_cfg_we / i_cfg_data only while idle; nothing checks it.
module blob_orientation_from_moments #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    bom_in_if.sink    i_req,
    bom_out_if.source o_res
);
    import bom_pkg::*;

    localparam int K_CORD = 4;
    localparam int K_TH   = CORDIC_STEPS + 4;
    localparam int K_MUL  = CORDIC_STEPS + 5;
    localparam int K_OUT  = CORDIC_STEPS + 6;
    localparam int NS     = CORDIC_STEPS + 7;

    logic r_degree_mode;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;
    t_side         r_side [NS];

    // stage 0: difference and doubled mixed moment
    logic signed [DIFF_W-1:0] r_a, r_b;
    logic signed [DIFF_W-1:0] n_a, n_b;
    t_side                    n_side0;
    // stage 1: magnitudes
    logic [DIFF_W-1:0] r_ua1, r_ub1;
    // stage 2: shift amount
    logic [DIFF_W-1:0] r_ua2, r_ub2;
    logic [5:0]        r_shamt;
    logic [DIFF_W-1:0] n_max;
    logic [5:0]        n_pos;
    // CORDIC chain; entry 0 comes from the normalizing shift
    logic signed [CORD_W-1:0] r_cx [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] r_cy [CORDIC_STEPS+1];
    logic signed [ZACC_W-1:0] r_cz [CORDIC_STEPS+1];
    // back end
    logic [THETA_W-1:0] r_theta, n_theta;
    logic [30:0]        n_alpha;
    logic [29:0]        n_c;
    logic [PROD_W-1:0]  r_prod;
    logic [ANGLE_W-1:0] r_angle, n_angle;
    logic [63:0]        n_sum, n_scaled;

    // ------------------------------------------------------------------
    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_degree_mode <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when empty or when its successor loads
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_ctl
            if (k == NS - 1) begin : g_last
                assign w_en[k] = !r_vld[k] || o_res.ready;
            end else begin : g_mid
                assign w_en[k] = !r_vld[k] || w_en[k+1];
            end
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[k] <= 1'b0;
                    end else if (w_en[k]) begin
                        r_vld[k] <= i_req.valid;
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (w_en[k]) begin
                        r_side[k] <= n_side0;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[k] <= 1'b0;
                    end else if (w_en[k]) begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (w_en[k]) begin
                        r_side[k] <= r_side[k-1];
                    end
                end
            end
        end
    endgenerate

    assign i_req.ready = w_en[0];

    // ------------------------------------------------------------------
    // stage 0
    always_comb begin
        n_a = DIFF_W'(i_req.moment_horizontal) - DIFF_W'(i_req.moment_vertical);
        n_b = {i_req.moment_mixed, 1'b0};
        n_side0.last   = i_req.last_blob_in;
        n_side0.a_zero = (n_a == '0);
        n_side0.a_neg  = n_a[DIFF_W-1];
        n_side0.b_neg  = i_req.moment_mixed[MOMENT_W-1];
        n_side0.b_zero = (i_req.moment_mixed == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    // stage 1: |b| = 2^32 is representable as unsigned
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_ua1 <= r_a[DIFF_W-1] ? (~r_a + 1'b1) : r_a;
            r_ub1 <= r_b[DIFF_W-1] ? (~r_b + 1'b1) : r_b;
        end
    end

    // stage 2: msb of the larger magnitude
    always_comb begin
        n_max = (r_ua1 > r_ub1) ? r_ua1 : r_ub1;
        n_pos = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (n_max[i]) begin
                n_pos = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_ua2   <= r_ua1;
            r_ub2   <= r_ub1;
            r_shamt <= 6'(NORM_MSB) - n_pos;
        end
    end

    // stage 3: normalize
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_cx[0] <= CORD_W'(r_ua2) << r_shamt;
            r_cy[0] <= CORD_W'(r_ub2) << r_shamt;
            r_cz[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring, one iteration per stage
    genvar j;
    generate
        for (j = 0; j < CORDIC_STEPS; j++) begin : g_cord
            logic signed [CORD_W-1:0] n_x, n_y;
            logic signed [ZACC_W-1:0] n_z;
            always_comb begin
                if (!r_cy[j][CORD_W-1]) begin
                    n_x = r_cx[j] + (r_cy[j] >>> j);
                    n_y = r_cy[j] - (r_cx[j] >>> j);
                    n_z = r_cz[j] + ZACC_W'(ATAN_TAB[j]);
                end else begin
                    n_x = r_cx[j] - (r_cy[j] >>> j);
                    n_y = r_cy[j] + (r_cx[j] >>> j);
                    n_z = r_cz[j] - ZACC_W'(ATAN_TAB[j]);
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en[K_CORD+j]) begin
                    r_cx[j+1] <= n_x;
                    r_cy[j+1] <= n_y;
                    r_cz[j+1] <= n_z;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // fold the half angle into [0, pi)
    always_comb begin
        if (r_cz[CORDIC_STEPS][ZACC_W-1]) begin
            n_alpha = '0;
        end else if (r_cz[CORDIC_STEPS] > ZACC_W'(33'd1 << 30)) begin
            n_alpha = 31'd1 << 30;
        end else begin
            n_alpha = r_cz[CORDIC_STEPS][30:0];
        end
        n_c = r_side[K_TH-1].b_zero ? 30'd0 : 30'((32'(n_alpha) + 32'd1) >> 1);
        priority if (r_side[K_TH-1].a_zero) begin
            n_theta = '0;
        end else if (!r_side[K_TH-1].a_neg) begin
            n_theta = r_side[K_TH-1].b_neg ? (32'd1 << 31) - 32'(n_c) : 32'(n_c);
        end else begin
            n_theta = r_side[K_TH-1].b_neg ? (32'd1 << 30) + 32'(n_c)
                                           : (32'd1 << 30) - 32'(n_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[K_TH]) begin
            r_theta <= n_theta;
        end
    end

    // scale multiply, 32 x 31
    always_ff @(posedge i_clk) begin
        if (w_en[K_MUL]) begin
            r_prod <= PROD_W'(r_theta) * PROD_W'(r_degree_mode ? DEG_SCALE : PI_Q29);
        end
    end

    // round, shift, saturate
    always_comb begin
        if (r_degree_mode) begin
            n_sum    = 64'(r_prod) + DEG_ROUND;
            n_scaled = n_sum >> DEG_SHIFT;
        end else begin
            n_sum    = 64'(r_prod) + RAD_ROUND;
            n_scaled = n_sum >> RAD_SHIFT;
        end
        n_angle = (n_scaled > 64'(ANGLE_MAX)) ? ANGLE_MAX : n_scaled[ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[K_OUT]) begin
            r_angle <= n_angle;
        end
    end

    assign o_res.valid         = r_vld[K_OUT];
    assign o_res.angle         = r_angle;
    assign o_res.last_blob_out = r_side[K_OUT].last;

    // ------------------------------------------------------------------
    // normalized vector: larger magnitude in [2^40, 2^41)
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r_side[3].a_zero && !r_side[3].b_zero) |->
        ((r_cx[0][NORM_MSB] || r_cy[0][NORM_MSB]) &&
         (r_cx[0][CORD_W-1:NORM_MSB+1] == '0) && (r_cy[0][CORD_W-1:NORM_MSB+1] == '0)))
        else $error("normalization out of range");

    // equal moments give zero angle
    a_zero_theta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[K_TH] && r_side[K_TH].a_zero) |-> (r_theta == '0))
        else $error("nonzero theta for equal moments");

    // theta never exceeds pi
    a_theta_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[K_TH] |-> (r_theta <= (32'd1 << 31)))
        else $error("theta above pi");

    // a stalled output stage keeps its result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[K_OUT] && !o_res.ready) |=> (r_vld[K_OUT] && $stable(r_angle)))
        else $error("output changed while stalled");

    a_angle_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[K_OUT] |-> (r_angle <= ANGLE_MAX))
        else $error("angle above limit");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: blob orientation from moments
// Streams directed and random moment requests through the CORDIC pipeline in
// radian and degree modes, under varying source gaps and sink stalls, and
// checks every angle and last flag in order against an integer CORDIC
// predictor.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [23:0] angle;
    logic        last;
} t_angle_result;

class orientation_board #(int STEPS = 24);

    t_angle_result pending_angles[$];
    bit            degree_mode;
    int unsigned   mismatches;
    int unsigned   angles_checked;

    function new();
        degree_mode    = 1'b0;
        mismatches     = 0;
        angles_checked = 0;
    endfunction

    task report(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // atan(ub/ua) in 2^-32 turn units, both magnitudes positive
    function longint vector_turns(longint unsigned ua, longint unsigned ub);
        longint turn_tab [32] = '{
            'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
            'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
            'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
            0, 0
        };
        longint unsigned big;
        longint          x;
        longint          y;
        longint          z;
        longint          nx;
        big = (ua > ub) ? ua : ub;
        while (big < (64'd1 << 40)) begin
            big = big << 1;
            ua  = ua << 1;
            ub  = ub << 1;
        end
        x = longint'(ua);
        y = longint'(ub);
        z = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + turn_tab[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - turn_tab[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
        return z;
    endfunction

    function logic [23:0] predict_orientation(logic signed [31:0] horiz,
                                              logic signed [31:0] vert,
                                              logic signed [31:0] mixed);
        longint          diff;
        longint          twice_mixed;
        longint unsigned half_turns;
        longint unsigned theta;
        longint unsigned scaled;
        diff        = longint'(horiz) - longint'(vert);
        twice_mixed = longint'(mixed) * 2;
        theta       = 0;
        if (diff != 0) begin
            half_turns = 0;
            if (twice_mixed != 0)
                half_turns = (longint'(vector_turns(diff < 0 ? -diff : diff,
                    twice_mixed < 0 ? -twice_mixed : twice_mixed)) + 1) >> 1;
            if (diff > 0)
                theta = (twice_mixed >= 0) ? half_turns : (64'd1 << 31) - half_turns;
            else
                theta = (twice_mixed >= 0) ? (64'd1 << 30) - half_turns
                                           : (64'd1 << 30) + half_turns;
        end
        if (!degree_mode)
            scaled = (theta * 64'd1686629713 + (64'd1 << 43)) >> 44;
        else
            scaled = (theta * 64'd45 + (64'd1 << 12)) >> 13;
        if (scaled > 64'd11796479) scaled = 64'd11796479;
        return scaled[23:0];
    endfunction

    function void note_blob(logic signed [31:0] horiz, logic signed [31:0] vert,
                            logic signed [31:0] mixed, logic last);
        t_angle_result exp_res;
        exp_res.angle = predict_orientation(horiz, vert, mixed);
        exp_res.last  = last;
        pending_angles.push_back(exp_res);
    endfunction

    task check_angle(logic [23:0] angle, logic last);
        t_angle_result exp_res;
        if (pending_angles.size() == 0) begin
            report($sformatf("angle %0d with no request outstanding", angle));
        end else begin
            exp_res = pending_angles.pop_front();
            angles_checked++;
            if (angle !== exp_res.angle)
                report($sformatf("angle %0d, predicted %0d", angle, exp_res.angle));
            if (last !== exp_res.last)
                report($sformatf("last flag %b, predicted %b", last, exp_res.last));
        end
    endtask

    function int pending();
        return pending_angles.size();
    endfunction

endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS      = 24;
    localparam int LATENCY    = STEPS + 7;
    localparam int CYCLE_CAP  = 300000;
    localparam int PHASE_LEN  = 140;

    localparam logic signed [31:0] MOM_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MOM_MIN = 32'sh80000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    bom_in_if  req_if ();
    bom_out_if res_if ();

    blob_orientation_from_moments #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    orientation_board #(STEPS) board;

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned cycle_count;
    int unsigned blobs_sent;
    int unsigned degree_blobs;

    // directed cases: equal moments, zero mixed moment both ways, tiny negative
    // half angle, field extremes, all four quadrants
    localparam int N_DIRECTED = 12;
    logic signed [31:0] dir_h [N_DIRECTED] = '{
        32'sd100, 32'sd1000, 32'sd0, 32'sd1000, MOM_MAX, MOM_MIN,
        MOM_MAX, MOM_MIN, 32'sd0, 32'sd1, 32'sd0, -32'sd5
    };
    logic signed [31:0] dir_v [N_DIRECTED] = '{
        32'sd100, 32'sd0, 32'sd1000, 32'sd0, MOM_MIN, MOM_MAX,
        MOM_MIN, MOM_MIN, 32'sd0, 32'sd0, 32'sd1, 32'sd3
    };
    logic signed [31:0] dir_m [N_DIRECTED] = '{
        32'sd50, 32'sd0, 32'sd0, -32'sd1, -32'sd1, MOM_MIN,
        MOM_MAX, MOM_MAX, 32'sd0, MOM_MAX, MOM_MIN, 32'sd7
    };

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout after %0d cycles, %0d angles outstanding",
                     cycle_count, board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sink side: random back-pressure
    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_angle(res_if.angle, res_if.last_blob_out);
    end

    task automatic send_blob(logic signed [31:0] horiz, logic signed [31:0] vert,
                             logic signed [31:0] mixed, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid             = 1'b1;
        req_if.moment_horizontal = horiz;
        req_if.moment_vertical   = vert;
        req_if.moment_mixed      = mixed;
        req_if.last_blob_in      = last;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_blob(horiz, vert, mixed, last);
        blobs_sent++;
        if (board.degree_mode) degree_blobs++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // only called with the pipeline empty
    task automatic write_degree_mode(bit mode);
        i_cfg_we   = 1'b1;
        i_cfg_data = mode;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.degree_mode = mode;
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(4))
            0: return MOM_MAX;
            1: return MOM_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic send_random_blob();
        logic signed [31:0] horiz;
        logic signed [31:0] vert;
        logic signed [31:0] mixed;
        horiz = $urandom;
        vert  = $urandom;
        mixed = $urandom;
        case ($urandom_range(9))
            4: vert = horiz;                                  // equal moments
            5: mixed = 32'sd0;                                // no mixed term
            6: begin
                horiz = $urandom_range(2000) - 1000;
                vert  = $urandom_range(2000) - 1000;
                mixed = $urandom_range(2000) - 1000;
            end
            7: begin
                horiz = pick_extreme();
                vert  = pick_extreme();
                mixed = pick_extreme();
            end
            8: vert = horiz + $urandom_range(16) - 8;         // near-equal moments
            9: mixed = $urandom_range(6) - 3;                 // angle close to an axis
            default: ;
        endcase
        send_blob(horiz, vert, mixed, $urandom_range(7) == 0);
    endtask

    task automatic run_random_phase(int unsigned n_items, int unsigned src_pct,
                                    int unsigned snk_pct, bit hold_midway);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (hold_midway && k == n_items / 2)
                wait_drained();
            send_random_blob();
        end
        wait_drained();
    endtask

    initial begin
        board         = new();
        cycle_count   = 0;
        blobs_sent    = 0;
        degree_blobs  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 1'b0;
        req_if.valid             = 1'b0;
        req_if.moment_horizontal = '0;
        req_if.moment_vertical   = '0;
        req_if.moment_mixed      = '0;
        req_if.last_blob_in      = 1'b0;
        res_if.ready             = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int mode = 0; mode < 2; mode++) begin
            write_degree_mode(mode[0]);
            for (int i = 0; i < N_DIRECTED; i++)
                send_blob(dir_h[i], dir_v[i], dir_m[i], i[0]);
            wait_drained();
        end

        // idle mixes: none, sender gaps, receiver stalls, both
        for (int p = 0; p < 8; p++) begin
            write_degree_mode(p[0]);
            case (p >> 1)
                0: run_random_phase(PHASE_LEN, 0, 0, 1'b0);
                1: run_random_phase(PHASE_LEN, 57, 0, 1'b0);
                2: run_random_phase(PHASE_LEN, 0, 57, p == 5);
                default: run_random_phase(PHASE_LEN, 28, 28, 1'b0);
            endcase
        end

        wait_drained();
        snk_stall_pct = 0;
        repeat (LATENCY + 8) @(negedge i_clk);

        $display("Sent %0d blobs (%0d in degree mode), %0d angles checked, %0d mismatches",
                 blobs_sent, degree_blobs, board.angles_checked, board.mismatches);
        $display("Covered axis and equal-moment cases, field extremes, four idle mixes");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
